### hdl/rmnu_pkg.sv
// ----------------------------------------------------------------------------
// rmnu_pkg
// shared types and constants of the regret matching node update unit
// ----------------------------------------------------------------------------
`default_nettype none

package rmnu_pkg;

    // default number of action slots per node
    localparam int RMNU_NUM_ACTIONS = 7;

    // field widths
    localparam int SLOT_W = 16;           // regret, child value, results
    localparam int NUM_W  = SLOT_W - 1;   // positive regret magnitude
    localparam int PROB_W = 16;           // probability, unsigned Q0.16
    localparam int QUO_W  = PROB_W + 1;   // quotient, holds 1.0 before clamping

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // register word indexes
    localparam logic [APB_AW-3:0] REG_THRESHOLD = 1'b0;

    // sequencer states
    typedef enum logic [2:0] {
        S_LOAD,
        S_SETUP,
        S_DIV,
        S_MUL,
        S_ACC,
        S_FINAL,
        S_OLOAD,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

### hdl/regret_matching_node_update_unit.sv
// ----------------------------------------------------------------------------
// regret_matching_node_update_unit
// regret matching strategy, node value and counterfactual regrets of one node
// ----------------------------------------------------------------------------
//  channel   direction  handshake                    payload
//  slot in   input      i_valid / o_ready            regret, child value, valid, last
//  result    output     o_valid / i_ready            action, probability, cf regret,
//                                                    node value, last
//  config    input      psel/penable/pwrite/pready   threshold at byte address 0
//
//  slot words are taken back to back while loading; the last slot starts the computation
//  each slot then passes through setup, the shared bit-serial divider (17 quotient
//  bits), one multiply and one accumulate; a final step forms the node value
//  each result word is loaded into the output register and held there until taken
//  synchronous active-low reset clears the sequencer, counters and threshold
//  no slot is taken while a node is computed or its results are delivered
// ----------------------------------------------------------------------------
`default_nettype none

module regret_matching_node_update_unit
    import rmnu_pkg::*;
#(
    parameter int NUM_ACTIONS = RMNU_NUM_ACTIONS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // slot channel
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic signed [SLOT_W-1:0]        i_slot_regret,
    input  wire logic signed [SLOT_W-1:0]        i_slot_child_value,
    input  wire logic                            i_slot_valid,
    input  wire logic                            i_slot_last,
    // result channel
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [$clog2(NUM_ACTIONS)-1:0]       o_action_number,
    output logic [PROB_W-1:0]                    o_probability,
    output logic signed [SLOT_W-1:0]             o_counterfactual_regret,
    output logic signed [SLOT_W-1:0]             o_node_value,
    output logic                                 o_result_last,
    // configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [APB_AW-1:0]               paddr,
    input  wire logic [APB_DW-1:0]               pwdata,
    output logic [APB_DW-1:0]                    prdata,
    output logic                                 pready
);

    localparam int IDX_W  = $clog2(NUM_ACTIONS);
    localparam int CNT_W  = $clog2(NUM_ACTIONS + 1);
    localparam int SUM_W  = NUM_W + $clog2(NUM_ACTIONS);
    localparam int PROD_W = QUO_W + SLOT_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int RND_W  = ACC_W - PROB_W;

    // saturate to a signed slot word
    function automatic logic signed [SLOT_W-1:0] sat_slot(input logic signed [RND_W-1:0] v);
        logic signed [RND_W-1:0] v_max;
        logic signed [RND_W-1:0] v_min;
        v_max = RND_W'(32767);
        v_min = -RND_W'(32768);
        if (v > v_max) begin
            sat_slot = 16'sh7fff;
        end else if (v < v_min) begin
            sat_slot = 16'sh8000;
        end else begin
            sat_slot = v[SLOT_W-1:0];
        end
    endfunction

    // sequencer
    t_state r_state;
    t_state n_state;

    // slot stores
    logic signed [SLOT_W-1:0] r_regret_store [NUM_ACTIONS];
    logic signed [SLOT_W-1:0] r_cv_store     [NUM_ACTIONS];
    logic [PROB_W-1:0]        r_prob_store   [NUM_ACTIONS];

    // node state
    logic [NUM_ACTIONS-1:0]   r_mask;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         r_legal;
    logic [SUM_W-1:0]         r_sum;
    logic [IDX_W-1:0]         r_idx;
    logic [PROB_W-1:0]        r_thr;
    logic                     r_pzero;
    logic                     r_pvalid;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [SLOT_W-1:0] r_node;

    // output registers
    logic                     r_out_valid;
    logic [IDX_W-1:0]         r_out_idx;
    logic [PROB_W-1:0]        r_out_prob;
    logic signed [SLOT_W-1:0] r_out_cf;
    logic signed [SLOT_W-1:0] r_out_node;
    logic                     r_out_last;

    // decoded controls
    logic s_in_ready;
    logic s_div_start;

    // datapath helpers
    logic                     s_in_acc;
    logic                     s_out_acc;
    logic                     s_slot_end;
    logic [IDX_W-1:0]         s_pos;
    logic                     s_idx_last;
    logic signed [SLOT_W-1:0] s_rg;
    logic signed [SLOT_W-1:0] s_cv;
    logic                     s_v;
    logic                     s_regret_mode;
    logic [NUM_W-1:0]         s_num;
    logic [SUM_W-1:0]         s_den;
    logic                     s_zero;
    logic                     s_div_busy;
    logic [QUO_W-1:0]         s_quo;
    logic [PROB_W-1:0]        s_prob;
    logic signed [ACC_W-1:0]  s_rnd;
    logic signed [RND_W-1:0]  s_cf_diff;
    logic                     s_cfg_wr;

    assign s_in_acc   = i_valid && o_ready;
    assign s_out_acc  = o_valid && i_ready;
    assign s_pos      = r_count[IDX_W-1:0];
    assign s_slot_end = i_slot_last || (r_count == CNT_W'(NUM_ACTIONS - 1));
    assign s_idx_last = (CNT_W'(r_idx) == (r_count - 1'b1));

    // current slot from the stores
    always_comb begin
        s_rg = r_regret_store[r_idx];
        s_cv = r_cv_store[r_idx];
        s_v  = r_mask[r_idx];
    end

    // divider operands: positive regret over the sum, or one over the legal count
    always_comb begin
        s_regret_mode = (r_sum > SUM_W'(r_thr));
        s_num  = '0;
        s_den  = r_sum;
        s_zero = 1'b1;
        if (r_legal == '0) begin
            s_zero = 1'b1;
        end else if (s_regret_mode) begin
            if (s_rg > 0) begin
                s_num  = s_rg[NUM_W-1:0];
                s_zero = 1'b0;
            end
        end else if (s_v) begin
            s_num  = NUM_W'(1);
            s_den  = SUM_W'(r_legal);
            s_zero = 1'b0;
        end
    end

    rmnu_div #(
        .SUM_W (SUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_div_start),
        .i_num   (s_num),
        .i_den   (s_den),
        .o_busy  (s_div_busy),
        .o_quo   (s_quo)
    );

    // zero for a slot with no share, else clamp 1.0 to the largest probability
    always_comb begin
        if (r_pzero) begin
            s_prob = '0;
        end else if (s_quo[QUO_W-1]) begin
            s_prob = '1;
        end else begin
            s_prob = s_quo[PROB_W-1:0];
        end
    end

    // node value rounding and counterfactual difference
    always_comb begin
        s_rnd     = r_acc + ACC_W'(32768);
        s_cf_diff = RND_W'(s_cv) - RND_W'(r_node);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (s_in_acc && s_slot_end) n_state = S_SETUP;
            end
            S_SETUP: n_state = S_DIV;
            S_DIV: begin
                if (!s_div_busy) n_state = S_MUL;
            end
            S_MUL: n_state = S_ACC;
            S_ACC: n_state = s_idx_last ? S_FINAL : S_SETUP;
            S_FINAL: n_state = S_OLOAD;
            S_OLOAD: n_state = S_EMIT;
            S_EMIT: begin
                if (s_out_acc) n_state = r_out_last ? S_LOAD : S_OLOAD;
            end
            default: n_state = S_LOAD;
        endcase
    end

    // state decode
    always_comb begin
        s_in_ready  = 1'b0;
        s_div_start = 1'b0;
        case (r_state)
            S_LOAD:  s_in_ready  = 1'b1;
            S_SETUP: s_div_start = 1'b1;
            default: begin
                s_in_ready  = 1'b0;
                s_div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // slot stores
    always_ff @(posedge i_clk) begin
        if (s_in_acc) begin
            r_regret_store[s_pos] <= i_slot_regret;
            r_cv_store[s_pos]     <= i_slot_child_value;
        end
        if (r_state == S_MUL) begin
            r_prob_store[r_idx] <= s_prob;
        end
    end

    // node control state: mask, counters, positive sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_count <= '0;
            r_legal <= '0;
            r_sum   <= '0;
            r_idx   <= '0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    r_idx <= '0;
                    if (s_in_acc) begin
                        r_mask[s_pos] <= i_slot_valid;
                        r_count       <= r_count + 1'b1;
                        r_legal       <= r_legal + CNT_W'(i_slot_valid);
                        if (i_slot_regret > 0) begin
                            r_sum <= r_sum + SUM_W'(i_slot_regret[NUM_W-1:0]);
                        end
                    end
                end
                S_ACC: begin
                    if (!s_idx_last) r_idx <= r_idx + 1'b1;
                end
                S_FINAL: r_idx <= '0;
                S_EMIT: begin
                    if (s_out_acc) begin
                        if (r_out_last) begin
                            r_mask  <= '0;
                            r_count <= '0;
                            r_legal <= '0;
                            r_sum   <= '0;
                            r_idx   <= '0;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // multiply and accumulate over the legal slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (r_state == S_LOAD) begin
            r_acc <= '0;
        end else if (r_state == S_ACC && r_pvalid) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SETUP) begin
            r_pzero <= s_zero;
        end
        if (r_state == S_MUL) begin
            r_prod   <= $signed({1'b0, s_prob}) * s_cv;
            r_pvalid <= s_v;
        end
        if (r_state == S_FINAL) begin
            r_node <= sat_slot(s_rnd[ACC_W-1:PROB_W]);
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OLOAD) begin
            r_out_valid <= 1'b1;
        end else if (s_out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OLOAD) begin
            r_out_idx  <= r_idx;
            r_out_prob <= r_prob_store[r_idx];
            r_out_node <= r_node;
            r_out_last <= s_idx_last;
            if (r_legal != '0 && s_v) begin
                r_out_cf <= sat_slot(s_cf_diff);
            end else begin
                r_out_cf <= '0;
            end
        end
    end

    // configuration register
    assign s_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (s_cfg_wr && paddr[APB_AW-1:2] == REG_THRESHOLD) begin
            r_thr <= pwdata[PROB_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[APB_AW-1:2] == REG_THRESHOLD) begin
            prdata = APB_DW'(r_thr);
        end
    end

    assign pready = 1'b1;

    // ports
    assign o_ready                 = s_in_ready;
    assign o_valid                 = r_out_valid;
    assign o_action_number         = r_out_idx;
    assign o_probability           = r_out_prob;
    assign o_counterfactual_regret = r_out_cf;
    assign o_node_value            = r_out_node;
    assign o_result_last           = r_out_last;

    // slots are never taken while results are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("slot taken while a result word is pending");

    // slot count never passes the number of actions
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(NUM_ACTIONS))
        else $error("slot counter out of range");

    // node state is cleared once the final result word is taken
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_out_acc && o_result_last) |=> (r_count == '0 && r_mask == '0 && r_sum == '0))
        else $error("node state not cleared after final result");

    // node value holds between result words of one node
    a_node_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_out_acc && !o_result_last) |=> $stable(r_node))
        else $error("node value changed within a node");

    // no legal slot gives zero probabilities and a zero node value
    a_zero_prob: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_legal == '0) |-> (o_probability == '0 && o_node_value == '0))
        else $error("nonzero result with no legal slot");

endmodule

`default_nettype wire

### hdl/rmnu_div.sv
// ----------------------------------------------------------------------------
// rmnu_div
// restoring divider, one quotient bit per cycle: (num << 16) / den
// ----------------------------------------------------------------------------
`default_nettype none

module rmnu_div
    import rmnu_pkg::*;
#(
    parameter int SUM_W = 18
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [SUM_W-1:0]  i_den,
    output logic                   o_busy,
    output logic [QUO_W-1:0]       o_quo
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [SUM_W-1:0] r_rem;
    logic [SUM_W-1:0] r_den;
    logic [QUO_W-1:0] r_dvd;
    logic [QUO_W-1:0] r_quo;
    logic [CNT_W-1:0] r_cnt;

    logic [SUM_W:0]   s_trial;
    logic             s_ge;
    logic [SUM_W:0]   s_diff;

    // trial subtract of the shifted remainder
    always_comb begin
        s_trial = {r_rem, r_dvd[QUO_W-1]};
        s_ge    = (s_trial >= {1'b0, r_den});
        s_diff  = s_trial - {1'b0, r_den};
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(QUO_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // remainder, dividend and quotient shift registers
    // upper dividend bits num >> 1 start as remainder, they stay below den
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= SUM_W'(i_num[NUM_W-1:1]);
            r_dvd <= {i_num[0], {(QUO_W-1){1'b0}}};
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_cnt != '0) begin
            r_rem <= s_ge ? s_diff[SUM_W-1:0] : s_trial[SUM_W-1:0];
            r_dvd <= {r_dvd[QUO_W-2:0], 1'b0};
            r_quo <= {r_quo[QUO_W-2:0], s_ge};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_quo;

    // remainder must stay below the divisor while stepping
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0 && r_den != '0) |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    // a start always leads to a full run of steps
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (r_cnt == CNT_W'(QUO_W)))
        else $error("divider did not start");

endmodule

`default_nettype wire

### verif/tb_regret_matching_node_update_unit.sv
// ----------------------------------------------------------------------------
// tb_regret_matching_node_update_unit
// self-checking bench for the regret matching node update unit
//
// slot words go in with random gaps, result words come out under random
// back-pressure. a behavioural model of the node update runs alongside and
// queues the expected result words of every node; each result word taken is
// compared field by field with the oldest one. a short table of hand-picked
// slots comes first, then random nodes under several thresholds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_regret_matching_node_update_unit
    import rmnu_pkg::*;
();

    localparam int NUM_ACT      = RMNU_NUM_ACTIONS;
    localparam int DRAIN_CYCLES = 60;
    localparam int TABLE_ROWS   = 22;
    localparam int SLOTS_PER_PH = 30;

    // one expected result word
    typedef struct {
        logic [2:0]         act;
        logic [PROB_W-1:0]  prob;
        logic signed [15:0] cf;
        logic signed [15:0] node;
        bit                 is_last;
    } t_action_result;

    // one hand-picked slot word, with its result typed in where obvious
    typedef struct {
        logic signed [15:0] regret;
        logic signed [15:0] child_value;
        bit                 legal;
        bit                 last;
        bit                 typed;
        logic [PROB_W-1:0]  prob;
        logic signed [15:0] cf;
        logic signed [15:0] node;
    } t_slot_row;

    // block ports
    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic signed [SLOT_W-1:0] i_slot_regret = '0;
    logic signed [SLOT_W-1:0] i_slot_child_value = '0;
    logic                     i_slot_valid = 1'b0;
    logic                     i_slot_last = 1'b0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic [2:0]               o_action_number;
    logic [PROB_W-1:0]        o_probability;
    logic signed [SLOT_W-1:0] o_counterfactual_regret;
    logic signed [SLOT_W-1:0] o_node_value;
    logic                     o_result_last;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_AW-1:0]        paddr = '0;
    logic [APB_DW-1:0]        pwdata = '0;
    logic [APB_DW-1:0]        prdata;
    logic                     pready;

    // model state of the node being collected
    logic signed [15:0] regret_mem [NUM_ACT];
    logic signed [15:0] value_mem [NUM_ACT];
    logic [NUM_ACT-1:0] legal_mask = '0;
    int                 slots_held = 0;
    int                 pos_regret_sum = 0;
    int                 thr_copy = 0;

    t_action_result strategy_q [$];
    int             mismatch_cnt = 0;
    bit             no_idle = 1'b0;
    int             ready_hold = 0;

    // hand-picked slots, threshold at its reset value of zero
    t_slot_row slot_table [TABLE_ROWS] = '{
        // lone legal slot, zero regret: uniform share clamps to 65535
        '{0, 16384, 1, 1, 1, 65535, 0, 16384},
        // lone illegal slot: no legal action, all zero
        '{32767, 0, 0, 1, 1, 0, 0, 0},
        // lone legal slot at the negative extremes
        '{-32768, -16384, 1, 1, 1, 65535, 0, -16384},
        // all weight on the second slot, counterfactual regret saturates
        '{0, 16384, 1, 0, 0, 0, 0, 0},
        '{32767, -16384, 1, 1, 0, 0, 0, 0},
        // seven slots without a last flag, illegal slot with positive regret
        '{1000, 8000, 1, 0, 0, 0, 0, 0},
        '{-300, -12000, 1, 0, 0, 0, 0, 0},
        '{2500, 4000, 0, 0, 0, 0, 0, 0},
        '{0, 16384, 1, 0, 0, 0, 0, 0},
        '{-32768, -16384, 0, 0, 0, 0, 0, 0},
        '{32767, 100, 1, 0, 0, 0, 0, 0},
        '{1, -1, 1, 0, 0, 0, 0, 0},
        // seven slots, no positive regret: uniform over three legal slots
        '{-1, 5000, 1, 0, 0, 0, 0, 0},
        '{-100, -5000, 0, 0, 0, 0, 0, 0},
        '{-32768, 16384, 1, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0, 0, 0},
        '{-5, -16384, 0, 0, 0, 0, 0, 0},
        '{-7, 3, 1, 0, 0, 0, 0, 0},
        '{-2, 12345, 0, 1, 0, 0, 0, 0},
        // early last flag after three slots
        '{256, -8192, 1, 0, 0, 0, 0, 0},
        '{512, 8192, 0, 0, 0, 0, 0, 0},
        '{-256, 16384, 1, 1, 0, 0, 0, 0}
    };

    regret_matching_node_update_unit u_dut (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_valid                 (i_valid),
        .o_ready                 (o_ready),
        .i_slot_regret           (i_slot_regret),
        .i_slot_child_value      (i_slot_child_value),
        .i_slot_valid            (i_slot_valid),
        .i_slot_last             (i_slot_last),
        .o_valid                 (o_valid),
        .i_ready                 (i_ready),
        .o_action_number         (o_action_number),
        .o_probability           (o_probability),
        .o_counterfactual_regret (o_counterfactual_regret),
        .o_node_value            (o_node_value),
        .o_result_last           (o_result_last),
        .psel                    (psel),
        .penable                 (penable),
        .pwrite                  (pwrite),
        .paddr                   (paddr),
        .pwdata                  (pwdata),
        .prdata                  (prdata),
        .pready                  (pready)
    );

    always #5 i_clk = ~i_clk;

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [15:0] clip16(input longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    // store one slot; on the closing slot work out strategy, node value and
    // counterfactual regrets and queue one result word per slot held
    task automatic regret_match_slot(input logic signed [15:0] regret,
                                     input logic signed [15:0] child_value,
                                     input bit legal, input bit last);
        int             pos;
        int             n;
        int             legal_cnt;
        int             prob [NUM_ACT];
        longint         p;
        longint         acc;
        logic signed [15:0] node;
        bit             by_regret;
        t_action_result res;
        pos = (slots_held >= NUM_ACT) ? NUM_ACT - 1 : slots_held;
        regret_mem[pos] = regret;
        value_mem[pos]  = child_value;
        legal_mask[pos] = legal;
        if (regret > 0)
            pos_regret_sum += int'(regret);
        slots_held = pos + 1;
        if (!last && pos < NUM_ACT - 1)
            return;

        n = pos + 1;
        legal_cnt = 0;
        for (int i = 0; i < n; i++)
            if (legal_mask[i])
                legal_cnt++;
        by_regret = pos_regret_sum > thr_copy;

        // strategy
        for (int i = 0; i < n; i++) begin
            p = 0;
            if (legal_cnt == 0)
                p = 0;
            else if (by_regret) begin
                if (regret_mem[i] > 0)
                    p = (longint'(regret_mem[i]) <<< 16) / pos_regret_sum;
            end else if (legal_mask[i])
                p = 65536 / legal_cnt;
            if (p > 65535)
                p = 65535;
            prob[i] = int'(p);
        end

        // node value, rounded to nearest with ties upwards
        node = '0;
        if (legal_cnt != 0) begin
            acc = 0;
            for (int i = 0; i < n; i++)
                if (legal_mask[i])
                    acc += longint'(prob[i]) * longint'(value_mem[i]);
            node = clip16((acc + 32768) >>> 16);
        end

        for (int i = 0; i < n; i++) begin
            res.act     = i[2:0];
            res.prob    = prob[i][15:0];
            res.cf      = (legal_cnt != 0 && legal_mask[i]) ?
                          clip16(longint'(value_mem[i]) - longint'(node)) : '0;
            res.node    = node;
            res.is_last = (i == n - 1);
            strategy_q.insert(strategy_q.size(), res);
        end

        slots_held     = 0;
        legal_mask     = '0;
        pos_regret_sum = 0;
    endtask

    // offer one slot word after a random gap and hold it until taken
    task automatic send_slot(input logic signed [15:0] regret,
                             input logic signed [15:0] child_value,
                             input bit legal, input bit last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid            <= 1'b1;
        i_slot_regret      <= regret;
        i_slot_child_value <= child_value;
        i_slot_valid       <= legal;
        i_slot_last        <= last;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        regret_match_slot(regret, child_value, legal, last);
    endtask

    function automatic logic signed [15:0] rand_regret();
        case ($urandom_range(0, 5))
            0, 1, 2: return 16'($urandom_range(0, 65535));
            3:       return 16'($urandom_range(0, 1024) - 512);
            4:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return '0;
        endcase
    endfunction

    function automatic logic signed [15:0] rand_child_value();
        if ($urandom_range(0, 5) == 0)
            return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
        return 16'($urandom_range(0, 32768) - 16384);
    endfunction

    // one random node: mostly seven slots closed by the last flag, some cut
    // short, some with the flag missing on the seventh slot
    task automatic drive_random_node(output int sent);
        int shape;
        int len;
        bit none_legal;
        shape      = $urandom_range(0, 9);
        none_legal = ($urandom_range(0, 19) == 0);
        len        = (shape == 6 || shape == 7) ? $urandom_range(1, NUM_ACT - 1) : NUM_ACT;
        for (int i = 0; i < len; i++)
            send_slot(rand_regret(), rand_child_value(),
                      !none_legal && ($urandom_range(0, 3) != 0),
                      (i == len - 1) && (shape != 8));
        sent = len;
    endtask

    // wait until every expected word is back, then let the block settle
    task automatic wait_drain();
        while (strategy_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_threshold_readback(input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {REG_THRESHOLD, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[15:0] !== value) begin
            $display("%0t ns: threshold readback expected %0d, got %0d",
                     $time, value, prdata[15:0]);
            mismatch_cnt++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_threshold(input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_THRESHOLD, 2'b00};
        pwdata  <= {16'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        thr_copy = int'(value);
        @(posedge i_clk);
        check_threshold_readback(value);
    endtask

    task automatic check_field(input string what, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, what, want_v, got_v);
            mismatch_cnt++;
        end
    endtask

    // result side: random back-pressure and comparison of every word taken
    always @(posedge i_clk) begin : result_side
        int             stall;
        t_action_result want;
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            ready_hold <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (strategy_q.size() == 0) begin
                    $display("%0t ns: result word for action %0d with none expected",
                             $time, o_action_number);
                    mismatch_cnt++;
                end else begin
                    want = strategy_q.pop_front();
                    check_field("action_number", want.act, o_action_number);
                    check_field("probability", want.prob, o_probability);
                    check_field("counterfactual_regret", want.cf, o_counterfactual_regret);
                    check_field("node_value", want.node, o_node_value);
                    check_field("result_last", want.is_last, o_result_last);
                end
            end
            if (ready_hold > 0) begin
                i_ready    <= 1'b0;
                ready_hold <= ready_hold - 1;
            end else begin
                stall = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
                i_ready    <= (stall == 0);
                ready_hold <= (stall == 0) ? 0 : stall - 1;
            end
        end
    end

    // main sequence
    initial begin : stimulus
        int             sent;
        int             len;
        logic [15:0]    thr;
        t_action_result typed_res;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_threshold_readback(16'd0);

        // hand-picked slots
        foreach (slot_table[k]) begin
            send_slot(slot_table[k].regret, slot_table[k].child_value,
                      slot_table[k].legal, slot_table[k].last);
            if (slot_table[k].typed) begin
                typed_res = '{act: 3'd0, prob: slot_table[k].prob, cf: slot_table[k].cf,
                              node: slot_table[k].node, is_last: 1'b1};
                strategy_q[strategy_q.size() - 1] = typed_res;
            end
        end
        i_valid <= 1'b0;
        wait_drain();

        // random nodes under several thresholds, one phase without idling
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       thr = 16'hffff;
                1:       thr = 16'($urandom_range(0, 2048));
                2:       thr = 16'h0000;
                default: thr = 16'($urandom_range(0, 65535));
            endcase
            no_idle = (ph == 2);
            set_threshold(thr);
            sent = 0;
            while (sent < SLOTS_PER_PH) begin
                drive_random_node(len);
                sent += len;
            end
            i_valid <= 1'b0;
            wait_drain();
        end

        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
